// ===== src/asrc_pkg.sv =====
// Package for the ADAS sample risk classifier: request and response payload
// structs, risk codes, register indexes, datapath widths and fixed coefficients.
// No dependencies; used by asrc_div and adas_sample_risk_classifier.
package asrc_pkg;

   // One sensor sample as it arrives on the request channel.
   typedef struct packed {
      logic [11:0] own_speed;
      logic [11:0] lead_speed;
      logic [15:0] radar_distance;
      logic [15:0] lidar_distance;
      logic [15:0] camera_distance;
      logic [11:0] left_lane_gap;
      logic [11:0] right_lane_gap;
   } req_type;

   // Risk grading codes.
   typedef logic [1:0] risk_type;
   localparam risk_type RISK_NONE = 2'd0;
   localparam risk_type RISK_WARN = 2'd1;
   localparam risk_type RISK_HIGH = 2'd2;

   // One classified sample on the response channel.
   typedef struct packed {
      logic [15:0] fused_distance;
      logic [15:0] safe_distance;
      risk_type    front_risk;
      risk_type    left_lane_risk;
      risk_type    right_lane_risk;
      risk_type    overall_risk;
   } rsp_type;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REACTION = 1'd1;

   // Reaction time codes.
   localparam logic [1:0] MODE_1S0 = 2'd0;
   localparam logic [1:0] MODE_1S5 = 2'd1;

   // Stopping distance datapath widths.
   localparam int NUM_W = 46;
   localparam int DEN_W = 31;
   localparam int Q_W = 16;
   localparam logic [Q_W-1:0] SAT_DIST = 16'hFFFF;

   // Reaction term coefficient 25*79461 times twice the reaction time.
   localparam logic [22:0] RT_COEF_1S0 = 23'd3973050;
   localparam logic [22:0] RT_COEF_1S5 = 23'd5959575;
   localparam logic [22:0] RT_COEF_2S0 = 23'd7946100;
   // Braking term coefficient and common denominator coefficient.
   localparam logic [20:0] BRAKE_COEF = 21'd1440000;
   localparam logic [20:0] DEN_COEF = 21'd1430298;

   // Lane margin: 500 mm base, growing above 80 km/h, attention band 200 mm.
   localparam logic [12:0] LANE_BASE = 13'd500;
   localparam logic [11:0] LANE_KNEE = 12'd800;
   localparam logic [12:0] LANE_BAND = 13'd200;

   // Side data that travels with an item through the divider.
   typedef struct packed {
      logic [15:0] fused;
      logic        own_le_lead;
      risk_type    lrisk;
      risk_type    rrisk;
      logic        sat;
      logic        num_zero;
   } side_type;

endpackage

// ===== src/adas_sample_risk_classifier.sv =====
// Top level of the ADAS sample risk classifier: configuration registers,
// operand stages, the asrc_div divider and the output register.
// Depends on asrc_pkg and asrc_div.
// Pipeline from an accepted request to its response: three operand stages,
// sixteen divider stages and one output register.
// Throughput: one request per cycle; the sixteen-stage divider, one quotient
// bit per stage, sets the depth. A stalled response freezes the whole pipeline.
// Reset clears all valid bits and loads friction 179 and reaction mode 1.
module adas_sample_risk_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  asrc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output asrc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [asrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [asrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NW = asrc_pkg::NUM_W;
   localparam int DW = asrc_pkg::DEN_W;
   localparam int QW = asrc_pkg::Q_W;

   logic [9:0] friction_ff;
   logic [1:0] mode_ff;
   logic       adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         friction_ff <= 10'd179;
         mode_ff     <= asrc_pkg::MODE_1S5;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            asrc_pkg::CSR_FRICTION: friction_ff <= csr_wdata;
            asrc_pkg::CSR_REACTION: mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register can take a new value.
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage A: median, lane grading, small products and coefficient selection.
   logic [15:0]        min_rl, max_rl, fused_in;
   logic [12:0]        margin_in;
   asrc_pkg::risk_type lrisk_in, rrisk_in;
   logic [21:0]        sf_in;
   logic [23:0]        ss_in;
   logic [22:0]        kt_in;
   logic [DW-1:0]      den_in;
   asrc_pkg::side_type a_side_in;

   always_comb begin
      min_rl = (req_data.radar_distance < req_data.lidar_distance) ?
               req_data.radar_distance : req_data.lidar_distance;
      max_rl = (req_data.radar_distance < req_data.lidar_distance) ?
               req_data.lidar_distance : req_data.radar_distance;
      if (req_data.camera_distance < min_rl) begin
         fused_in = min_rl;
      end else if (req_data.camera_distance > max_rl) begin
         fused_in = max_rl;
      end else begin
         fused_in = req_data.camera_distance;
      end
   end

   always_comb begin
      margin_in = asrc_pkg::LANE_BASE;
      if (req_data.own_speed > asrc_pkg::LANE_KNEE) begin
         margin_in = asrc_pkg::LANE_BASE
                   + 13'(req_data.own_speed - asrc_pkg::LANE_KNEE);
      end
      if (13'(req_data.left_lane_gap) < margin_in) begin
         lrisk_in = asrc_pkg::RISK_HIGH;
      end else if (13'(req_data.left_lane_gap) < margin_in + asrc_pkg::LANE_BAND) begin
         lrisk_in = asrc_pkg::RISK_WARN;
      end else begin
         lrisk_in = asrc_pkg::RISK_NONE;
      end
      if (13'(req_data.right_lane_gap) < margin_in) begin
         rrisk_in = asrc_pkg::RISK_HIGH;
      end else if (13'(req_data.right_lane_gap) < margin_in + asrc_pkg::LANE_BAND) begin
         rrisk_in = asrc_pkg::RISK_WARN;
      end else begin
         rrisk_in = asrc_pkg::RISK_NONE;
      end
   end

   always_comb begin
      unique case (mode_ff)
         asrc_pkg::MODE_1S0: kt_in = asrc_pkg::RT_COEF_1S0;
         asrc_pkg::MODE_1S5: kt_in = asrc_pkg::RT_COEF_1S5;
         default:            kt_in = asrc_pkg::RT_COEF_2S0;
      endcase
      sf_in  = 22'(req_data.own_speed) * 22'(friction_ff);
      ss_in  = 24'(req_data.own_speed) * 24'(req_data.own_speed);
      den_in = DW'(friction_ff) * DW'(asrc_pkg::DEN_COEF);
      a_side_in             = '0;
      a_side_in.fused       = fused_in;
      a_side_in.own_le_lead = (req_data.own_speed <= req_data.lead_speed);
      a_side_in.lrisk       = lrisk_in;
      a_side_in.rrisk       = rrisk_in;
   end

   logic               a_valid_ff;
   logic [21:0]        a_sf_ff;
   logic [23:0]        a_ss_ff;
   logic [22:0]        a_kt_ff;
   logic [DW-1:0]      a_den_ff;
   asrc_pkg::side_type a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sf_ff   <= sf_in;
         a_ss_ff   <= ss_in;
         a_kt_ff   <= kt_in;
         a_den_ff  <= den_in;
         a_side_ff <= a_side_in;
      end
   end

   // Stage B: reaction and braking terms of the numerator.
   logic               b_valid_ff;
   logic [44:0]        b_p1_ff, b_p2_ff;
   logic [DW-1:0]      b_den_ff;
   asrc_pkg::side_type b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_p1_ff   <= 45'(a_sf_ff) * 45'(a_kt_ff);
         b_p2_ff   <= 45'(a_ss_ff) * 45'(asrc_pkg::BRAKE_COEF);
         b_den_ff  <= a_den_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // Stage C: numerator sum and the saturation check ahead of division.
   logic [NW-1:0]      num_in;
   asrc_pkg::side_type c_side_in;

   always_comb begin
      num_in    = NW'(b_p1_ff) + NW'(b_p2_ff);
      c_side_in = b_side_ff;
      c_side_in.num_zero = (num_in == '0);
      c_side_in.sat = ({1'b0, num_in} >= {b_den_ff, {QW{1'b0}}}) && (num_in != '0);
   end

   logic               c_valid_ff;
   logic [NW-1:0]      c_num_ff;
   logic [DW-1:0]      c_den_ff;
   asrc_pkg::side_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_num_ff  <= num_in;
         c_den_ff  <= b_den_ff;
         c_side_ff <= c_side_in;
      end
   end

   // Division stages.
   logic               d_valid;
   logic [QW-1:0]      d_quot;
   asrc_pkg::side_type d_side;

   asrc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_valid_ff),
      .in_num    (c_num_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_side  (d_side)
   );

   // Final grading of the front risk and the overall maximum.
   asrc_pkg::rsp_type  rsp_in;
   logic [QW-1:0]      safe_in;
   asrc_pkg::risk_type front_in, lane_max;

   always_comb begin
      if (d_side.sat) begin
         safe_in = asrc_pkg::SAT_DIST;
      end else if (d_side.num_zero) begin
         safe_in = '0;
      end else begin
         safe_in = d_quot;
      end
      if (d_side.own_le_lead || (d_side.fused >= safe_in)) begin
         front_in = asrc_pkg::RISK_NONE;
      end else if ({d_side.fused, 1'b0} >= {1'b0, safe_in}) begin
         front_in = asrc_pkg::RISK_WARN;
      end else begin
         front_in = asrc_pkg::RISK_HIGH;
      end
      lane_max = (d_side.lrisk > d_side.rrisk) ? d_side.lrisk : d_side.rrisk;
      rsp_in.fused_distance  = d_side.fused;
      rsp_in.safe_distance   = safe_in;
      rsp_in.front_risk      = front_in;
      rsp_in.left_lane_risk  = d_side.lrisk;
      rsp_in.right_lane_risk = d_side.rrisk;
      rsp_in.overall_risk    = (front_in > lane_max) ? front_in : lane_max;
   end

   // Output register.
   asrc_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The overall code is never below any of the individual codes.
   a_overall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.overall_risk >= rsp_data.front_risk)
                  && (rsp_data.overall_risk >= rsp_data.left_lane_risk)
                  && (rsp_data.overall_risk >= rsp_data.right_lane_risk)))
      else $error("overall risk below a component risk");

   // Any front risk implies the fused range is short of the safe distance.
   a_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.front_risk != asrc_pkg::RISK_NONE))
      |-> (rsp_data.fused_distance < rsp_data.safe_distance))
      else $error("front risk raised with enough range");

   // A request accepted while the pipeline advances shows up in stage A.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> a_valid_ff)
      else $error("accepted request lost at pipeline entry");

   // Reset leaves no response pending.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

// ===== src/asrc_div.sv =====
// Pipelined restoring divider for the stopping distance, one quotient bit per
// register stage, with side data carried alongside. Depends on asrc_pkg.
module asrc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [asrc_pkg::NUM_W-1:0] in_num,
   input  logic [asrc_pkg::DEN_W-1:0] in_den,
   input  asrc_pkg::side_type        in_side,
   output logic                      out_valid,
   output logic [asrc_pkg::Q_W-1:0]  out_quot,
   output asrc_pkg::side_type        out_side
);

   localparam int NW = asrc_pkg::NUM_W;
   localparam int DW = asrc_pkg::DEN_W;
   localparam int QW = asrc_pkg::Q_W;

   logic              valid_ff [1:QW];
   logic [NW-1:0]     rem_ff   [1:QW];
   logic [DW-1:0]     den_ff   [1:QW];
   logic [QW-1:0]     quot_ff  [1:QW];
   asrc_pkg::side_type side_ff [1:QW];

   // Each stage tries to subtract the shifted divisor and sets one bit.
   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int B = QW - 1 - k;
      logic               valid_cur;
      logic [NW-1:0]      rem_cur;
      logic [DW-1:0]      den_cur;
      logic [QW-1:0]      quot_cur;
      asrc_pkg::side_type side_cur;
      logic [NW:0]   diff;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      // The first stage takes the operands straight from the inputs.
      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = in_num;
         assign den_cur   = in_den;
         assign quot_cur  = '0;
         assign side_cur  = in_side;
      end else begin : g_next
         assign valid_cur = valid_ff[k];
         assign rem_cur   = rem_ff[k];
         assign den_cur   = den_ff[k];
         assign quot_cur  = quot_ff[k];
         assign side_cur  = side_ff[k];
      end

      always_comb begin
         diff = {1'b0, rem_cur} - ((NW + 1)'(den_cur) << B);
         if (!diff[NW]) begin
            rem_in  = diff[NW-1:0];
            quot_in = quot_cur | (QW'(1) << B);
         end else begin
            rem_in  = rem_cur;
            quot_in = quot_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_cur;
            quot_ff[k+1] <= quot_in;
            side_ff[k+1] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quot  = quot_ff[QW];
   assign out_side  = side_ff[QW];

   // A stage that is not advancing keeps its valid bit.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> (valid_ff[QW] == $past(valid_ff[QW])))
      else $error("divider output valid changed while held");

   // The remainder at the end is always below the divisor for a live item
   // that was flagged neither as saturated nor as a zero dividend.
   a_rem: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_side.sat && !out_side.num_zero)
      |-> (rem_ff[QW] < NW'(den_ff[QW])))
      else $error("divider remainder not reduced");

   // A zero dividend always yields a zero remainder.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_side.num_zero) |-> (rem_ff[QW] == '0))
      else $error("zero dividend left a remainder");

endmodule
